FILE: design/nta_pkg.sv
// Package for the number-to-ASCII formatter: modes, FSM states, control
// structs, character constants and the digit-to-character function.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nta_pkg;

    // Digit shift register: ten BCD digits, the most significant at the top
    localparam int DigW   = 40;
    localparam int WordW  = 32;
    localparam int NumDec = 10;

    // Digit slots per mode
    localparam logic [5:0] MaxDec = 6'd10;
    localparam logic [5:0] MaxHex = 6'd8;
    localparam logic [5:0] MaxBin = 6'd32;

    // Last double-dabble step
    localparam logic [4:0] ConvLast = 5'd31;

    // ASCII codes
    localparam logic [6:0] CharZero  = 7'h30;
    localparam logic [6:0] CharA     = 7'h41;
    localparam logic [6:0] CharPlus  = 7'h2B;
    localparam logic [6:0] CharMinus = 7'h2D;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Sequencer to digit shift register
    typedef struct packed {
        logic load;   // take a new word
        logic dec;    // decimal load: clear digits, word goes to source
        logic conv;   // one double-dabble step
        logic shift;  // drop the top digit
        logic bin;    // digits are one bit wide
    } ctl_t;

    // Sequencer to output stage
    typedef struct packed {
        logic valid;  // put one character into the output register
        logic sign;   // the character is the sign
        logic last;   // final character of the number
    } emit_t;

    // 0-9 -> '0'-'9', 10-15 -> 'A'-'F'
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] wide;
        wide = {3'b000, d};
        if (d < 4'd10)
            return CharZero + wide;
        else
            return CharA + wide - 7'd10;
    endfunction

endpackage

`default_nettype wire

FILE: design/fixed_length_number_to_ascii_digits_top.sv
// Top level of the number-to-ASCII formatter: stream ports, sign handling,
// column tracking and output register. Depends on nta_pkg, nta_digits, nta_seq.
//
// One number is taken at a time and turned into one transfer per character,
// most significant digit first. Decimal items first go through a bit-serial
// double-dabble conversion, one source bit per cycle; every mode then drops
// unwanted high digits one per cycle (slots minus digit_count), hands over to
// emission and sends the optional sign and the digits one per cycle while
// the output register can take them.
// A new item is accepted once the last character sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module fixed_length_number_to_ascii_digits_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // value[31:0], digit_count[37:32], text_line[40:38], start_column[45:41], zero pad
    input  wire logic [47:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_line[2:0], out_column[8:3], ascii_char[15:9]
    output logic [15:0]      m_tdata,
    // last_char
    output logic             m_tlast
);

    logic                       start;
    logic                       idle;
    logic                       out_free;
    logic [nta_pkg::WordW-1:0]  in_value;
    logic [5:0]                 in_count;
    logic [2:0]                 in_line;
    logic [4:0]                 in_column;
    logic                       in_neg;
    logic [nta_pkg::WordW-1:0]  magnitude;
    logic [3:0]                 top_digit;
    nta_pkg::ctl_t              ctl;
    nta_pkg::emit_t             emit;

    logic       neg_reg;
    logic       neg_next;
    logic [2:0] line_reg;
    logic [2:0] line_next;
    logic [5:0] col_reg;
    logic [5:0] col_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [2:0] out_line_reg;
    logic [2:0] out_line_next;
    logic [5:0] out_column_reg;
    logic [5:0] out_column_next;
    logic [6:0] ascii_char_reg;
    logic [6:0] ascii_char_next;
    logic       last_char_reg;
    logic       last_char_next;

    // Unpack the input transfer
    assign in_value  = s_tdata[31:0];
    assign in_count  = s_tdata[37:32];
    assign in_line   = s_tdata[40:38];
    assign in_column = s_tdata[45:41];
    assign s_tready  = idle;
    assign start     = s_tvalid && idle;
    assign out_free  = !m_valid_reg || m_tready;

    // Magnitude of a negative signed value
    assign in_neg    = (nta_pkg::mode_t'(s_tuser) == nta_pkg::MODE_SDEC) &&
                       in_value[nta_pkg::WordW-1];
    assign magnitude = in_neg ? (~in_value + 32'd1) : in_value;

    nta_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_mode  (s_tuser),
        .in_count (in_count),
        .out_free (out_free),
        .idle     (idle),
        .ctl      (ctl),
        .emit     (emit)
    );

    nta_digits u_digits (
        .clk       (clk),
        .ctl       (ctl),
        .load_word (magnitude),
        .top_digit (top_digit)
    );

    // Per-item line, column and sign
    always_comb
    begin
        neg_next  = neg_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (start)
        begin
            neg_next  = in_neg;
            line_next = in_line;
            col_next  = {1'b0, in_column};
        end
        else if (emit.valid)
        begin
            col_next = col_reg + 6'd1;
        end
    end

    // Output register
    always_comb
    begin
        m_valid_next    = m_valid_reg;
        out_line_next   = out_line_reg;
        out_column_next = out_column_reg;
        ascii_char_next = ascii_char_reg;
        last_char_next  = last_char_reg;
        if (emit.valid)
        begin
            m_valid_next    = 1'b1;
            out_line_next   = line_reg;
            out_column_next = col_reg;
            last_char_next  = emit.last;
            if (emit.sign)
                ascii_char_next = neg_reg ? nta_pkg::CharMinus : nta_pkg::CharPlus;
            else
                ascii_char_next = nta_pkg::digit_char(top_digit);
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        line_reg       <= line_next;
        col_reg        <= col_next;
        out_line_reg   <= out_line_next;
        out_column_reg <= out_column_next;
        ascii_char_reg <= ascii_char_next;
        last_char_reg  <= last_char_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ascii_char_reg, out_column_reg, out_line_reg};
    assign m_tlast  = last_char_reg;

endmodule

`default_nettype wire

FILE: design/nta_digits.sv
// Digit shift register: bit-serial double-dabble for decimal, then one digit
// shifted out of the top per step. Depends on nta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nta_digits (
    input  wire logic                         clk,
    input  wire nta_pkg::ctl_t                ctl,
    input  wire logic [nta_pkg::WordW-1:0]    load_word,
    output logic      [3:0]                   top_digit
);

    logic [nta_pkg::DigW-1:0]  dig_reg;
    logic [nta_pkg::DigW-1:0]  dig_next;
    logic [nta_pkg::WordW-1:0] src_reg;
    logic [nta_pkg::WordW-1:0] src_next;
    logic [nta_pkg::DigW-1:0]  adj;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < nta_pkg::NumDec; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = dig_reg[i*4 +: 4];
        end
    end

    // Load, convert or shift out
    always_comb
    begin
        dig_next = dig_reg;
        src_next = src_reg;
        if (ctl.load)
        begin
            if (ctl.dec)
            begin
                dig_next = '0;
                src_next = load_word;
            end
            else
            begin
                dig_next = {load_word, 8'h00};
            end
        end
        else if (ctl.conv)
        begin
            dig_next = {adj[nta_pkg::DigW-2:0], src_reg[nta_pkg::WordW-1]};
            src_next = {src_reg[nta_pkg::WordW-2:0], 1'b0};
        end
        else if (ctl.shift)
        begin
            if (ctl.bin)
                dig_next = {dig_reg[nta_pkg::DigW-2:0], 1'b0};
            else
                dig_next = {dig_reg[nta_pkg::DigW-5:0], 4'h0};
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        src_reg <= src_next;
    end

    assign top_digit = ctl.bin ? {3'b000, dig_reg[nta_pkg::DigW-1]}
                               : dig_reg[nta_pkg::DigW-1 -: 4];

endmodule

`default_nettype wire

FILE: design/nta_seq.sv
// Sequencer: conversion, alignment and emission counters and the FSM that
// drives the digit register and the output stage. Depends on nta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nta_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     in_mode,
    input  wire logic [5:0]     in_count,
    input  wire logic           out_free,
    output logic                idle,
    output nta_pkg::ctl_t       ctl,
    output nta_pkg::emit_t      emit
);

    nta_pkg::state_t state_reg;
    nta_pkg::state_t state_next;
    logic [4:0]      conv_cnt_reg;
    logic [4:0]      conv_cnt_next;
    logic [5:0]      align_reg;
    logic [5:0]      align_next;
    logic [5:0]      rem_reg;
    logic [5:0]      rem_next;
    logic            signed_reg;
    logic            signed_next;
    logic            bin_reg;
    logic            bin_next;
    nta_pkg::mode_t  mode;
    logic [5:0]      max_digits;
    logic [5:0]      count_clamped;
    logic            is_dec;

    // Slot count per mode and clamped digit count
    always_comb
    begin
        mode = nta_pkg::mode_t'(in_mode);
        unique case (mode)
            nta_pkg::MODE_HEX: max_digits = nta_pkg::MaxHex;
            nta_pkg::MODE_BIN: max_digits = nta_pkg::MaxBin;
            default:           max_digits = nta_pkg::MaxDec;
        endcase
        count_clamped = (in_count > max_digits) ? max_digits : in_count;
        is_dec = (mode == nta_pkg::MODE_UDEC) || (mode == nta_pkg::MODE_SDEC);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nta_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = is_dec ? nta_pkg::ST_CONV : nta_pkg::ST_ALIGN;
            end
            nta_pkg::ST_CONV:
            begin
                if (conv_cnt_reg == nta_pkg::ConvLast)
                    state_next = nta_pkg::ST_ALIGN;
            end
            nta_pkg::ST_ALIGN:
            begin
                if (align_reg == 6'd0)
                begin
                    if (signed_reg)
                        state_next = nta_pkg::ST_SIGN;
                    else if (rem_reg == 6'd0)
                        state_next = nta_pkg::ST_IDLE;
                    else
                        state_next = nta_pkg::ST_EMIT;
                end
            end
            nta_pkg::ST_SIGN:
            begin
                if (out_free)
                    state_next = (rem_reg == 6'd0) ? nta_pkg::ST_IDLE : nta_pkg::ST_EMIT;
            end
            nta_pkg::ST_EMIT:
            begin
                if (out_free && rem_reg == 6'd1)
                    state_next = nta_pkg::ST_IDLE;
            end
            default: state_next = nta_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        idle       = (state_reg == nta_pkg::ST_IDLE);
        ctl.load   = start;
        ctl.dec    = is_dec;
        ctl.conv   = (state_reg == nta_pkg::ST_CONV);
        ctl.shift  = ((state_reg == nta_pkg::ST_ALIGN) && (align_reg != 6'd0)) ||
                     ((state_reg == nta_pkg::ST_EMIT) && out_free);
        ctl.bin    = bin_reg;
        emit.valid = ((state_reg == nta_pkg::ST_SIGN) ||
                      (state_reg == nta_pkg::ST_EMIT)) && out_free;
        emit.sign  = (state_reg == nta_pkg::ST_SIGN);
        emit.last  = (state_reg == nta_pkg::ST_SIGN) ? (rem_reg == 6'd0)
                                                     : (rem_reg == 6'd1);
    end

    // Counters and per-item flags
    always_comb
    begin
        conv_cnt_next = conv_cnt_reg;
        align_next    = align_reg;
        rem_next      = rem_reg;
        signed_next   = signed_reg;
        bin_next      = bin_reg;
        if (start)
        begin
            conv_cnt_next = 5'd0;
            align_next    = max_digits - count_clamped;
            rem_next      = count_clamped;
            signed_next   = (mode == nta_pkg::MODE_SDEC);
            bin_next      = (mode == nta_pkg::MODE_BIN);
        end
        else
        begin
            if (state_reg == nta_pkg::ST_CONV)
                conv_cnt_next = conv_cnt_reg + 5'd1;
            if (state_reg == nta_pkg::ST_ALIGN && align_reg != 6'd0)
                align_next = align_reg - 6'd1;
            if (state_reg == nta_pkg::ST_EMIT && out_free)
                rem_next = rem_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nta_pkg::ST_IDLE;
            conv_cnt_reg <= 5'd0;
            align_reg    <= 6'd0;
            rem_reg      <= 6'd0;
            signed_reg   <= 1'b0;
            bin_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            conv_cnt_reg <= conv_cnt_next;
            align_reg    <= align_next;
            rem_reg      <= rem_next;
            signed_reg   <= signed_next;
            bin_reg      <= bin_next;
        end
    end

    // The last of the 32 double-dabble steps hands over to alignment
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nta_pkg::ST_CONV && conv_cnt_reg == nta_pkg::ConvLast)
        |=> (state_reg == nta_pkg::ST_ALIGN))
        else $error("conversion did not hand over to alignment");

    // Emission never runs with nothing left to send
    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nta_pkg::ST_EMIT) |-> (rem_reg != 6'd0))
        else $error("emit state with zero characters left");

    // Digit and alignment counts never exceed the widest mode
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg <= nta_pkg::MaxBin) && (align_reg <= nta_pkg::MaxBin))
        else $error("digit counters out of range");

    // A sign only appears for signed items
    a_sign_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nta_pkg::ST_SIGN) |-> signed_reg)
        else $error("sign emitted for an unsigned item");

endmodule

`default_nettype wire

FILE: sim/nta_char_checker.sv
// Checker for the number-to-ASCII formatter: watches both stream channels,
// predicts the characters of each accepted number and compares every output.
// Depends on nta_pkg for the mode enum, digit slot counts and ASCII codes.
`timescale 1ns / 1ps

module nta_char_checker
    import nta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [2:0] line;
        logic [5:0] column;
        logic [6:0] code;
        logic       last;
    } text_char_t;

    // Characters still owed by the block, oldest first
    text_char_t char_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Work out the characters of one number and queue them
    task automatic format_number(input mode_t mode, input logic [31:0] value,
                                 input logic [5:0] count, input logic [2:0] line,
                                 input logic [4:0] col);
        logic [31:0] mag;
        logic [31:0] rest;
        logic [5:0]  ndig;
        logic [5:0]  pos;
        logic [3:0]  digs [32];
        logic [3:0]  d;
        text_char_t  c;
        int          p;
        case (mode)
            MODE_HEX: ndig = (count > MaxHex) ? MaxHex : count;
            MODE_BIN: ndig = (count > MaxBin) ? MaxBin : count;
            default:  ndig = (count > MaxDec) ? MaxDec : count;
        endcase
        mag = value;
        pos = {1'b0, col};
        c.line = line;
        // sign goes first, digits move one column right
        if (mode == MODE_SDEC)
        begin
            c.column = pos;
            c.code   = value[31] ? CharMinus : CharPlus;
            c.last   = (ndig == 6'd0);
            char_q.push_back(c);
            if (value[31])
                mag = ~value + 32'd1;
            pos = pos + 6'd1;
        end
        // digits of the magnitude, least significant first
        rest = mag;
        for (p = 0; p < 32; p++)
        begin
            case (mode)
                MODE_HEX: digs[p] = 4'((mag >> (4 * p)) & 32'hF);
                MODE_BIN: digs[p] = 4'((mag >> p) & 32'h1);
                default:
                begin
                    digs[p] = 4'(rest % 32'd10);
                    rest    = rest / 32'd10;
                end
            endcase
        end
        for (p = 0; p < ndig; p++)
        begin
            d        = digs[ndig - 1 - p];
            c.column = pos + 6'(p);
            c.code   = (d < 4'd10) ? CharZero + {3'b000, d} : CharA + {3'b000, d} - 7'd10;
            c.last   = (p == ndig - 1);
            char_q.push_back(c);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk)
    begin
        text_char_t got;
        text_char_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                format_number(mode_t'(s_tuser), s_tdata[31:0], s_tdata[37:32],
                              s_tdata[40:38], s_tdata[45:41]);
            if (m_tvalid && m_tready)
            begin
                got.line   = m_tdata[2:0];
                got.column = m_tdata[8:3];
                got.code   = m_tdata[15:9];
                got.last   = m_tlast;
                if (char_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (got != want)
                        errors++;
                    if (got.line != want.line)
                        $display("%0t: line mismatch, expected %0d, got %0d",
                                 $time, want.line, got.line);
                    if (got.column != want.column)
                        $display("%0t: column mismatch, expected %0d, got %0d",
                                 $time, want.column, got.column);
                    if (got.code != want.code)
                        $display("%0t: char mismatch, expected %h, got %h",
                                 $time, want.code, got.code);
                    if (got.last != want.last)
                        $display("%0t: tlast mismatch, expected %b, got %b",
                                 $time, want.last, got.last);
                end
            end
        end
        pending = char_q.size();
    end

endmodule

FILE: sim/fixed_length_number_to_ascii_digits_top_tb.sv
// Testbench top for the number-to-ASCII formatter: clock, reset, stimulus,
// output back-pressure, watchdog and verdict. Depends on nta_pkg, the block
// and nta_char_checker.
`timescale 1ns / 1ps

module fixed_length_number_to_ascii_digits_top_tb;
    import nta_pkg::*;

    localparam int IdlePct    = 32;
    localparam int HoldCycles = 400;
    localparam int StallLimit = 3000;
    localparam int RandItems  = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int   errors;
    int   pending;
    int   quiet_cycles = 0;
    logic calm = 1'b0;      // no idling on either side
    logic hold_req = 1'b0;  // ask the receiver for one long hold-off
    logic hold_done = 1'b0;

    always #4 clk = ~clk;

    fixed_length_number_to_ascii_digits_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    nta_char_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // Offer one number and wait for its transfer
    task automatic send_number(input mode_t mode, input logic [31:0] value,
                               input logic [5:0] count, input logic [2:0] line,
                               input logic [4:0] col);
        while (!calm && $urandom_range(0, 99) < IdlePct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, col, line, count, value};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("fixed_length_number_to_ascii_digits_top_tb failed");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        mode_t       mode;
        logic [31:0] value;
        logic [5:0]  count;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_UDEC;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unsigned decimal: extremes, clamping, dropped high digits, no digits
        send_number(MODE_UDEC, 32'd0,          6'd10, 3'd1, 5'd1);
        send_number(MODE_UDEC, 32'hFFFF_FFFF,  6'd10, 3'd4, 5'd16);
        send_number(MODE_UDEC, 32'd123456789,  6'd63, 3'd0, 5'd31);
        send_number(MODE_UDEC, 32'd12345,      6'd3,  3'd7, 5'd0);
        send_number(MODE_UDEC, 32'd987,        6'd0,  3'd2, 5'd5);
        // signed decimal: zero, most negative, clamped, no digits
        send_number(MODE_SDEC, 32'd0,          6'd5,  3'd1, 5'd1);
        send_number(MODE_SDEC, 32'h8000_0000,  6'd10, 3'd2, 5'd3);
        send_number(MODE_SDEC, 32'h7FFF_FFFF,  6'd63, 3'd3, 5'd31);
        send_number(MODE_SDEC, 32'hFFFF_FFFF,  6'd1,  3'd4, 5'd2);
        send_number(MODE_SDEC, 32'hFFFF_FF85,  6'd0,  3'd5, 5'd7);
        send_number(MODE_SDEC, 32'd42,         6'd0,  3'd6, 5'd8);
        send_number(MODE_SDEC, 32'd2147483647, 6'd4,  3'd7, 5'd30);
        // hexadecimal: all letters, clamping, truncation, no digits
        send_number(MODE_HEX,  32'hFFFF_FFFF,  6'd8,  3'd1, 5'd1);
        send_number(MODE_HEX,  32'h0123_4567,  6'd63, 3'd2, 5'd9);
        send_number(MODE_HEX,  32'h89AB_CDEF,  6'd8,  3'd3, 5'd31);
        send_number(MODE_HEX,  32'hDEAD_BEEF,  6'd3,  3'd0, 5'd0);
        send_number(MODE_HEX,  32'h1234_5678,  6'd0,  3'd4, 5'd4);
        // binary: full width, clamping, single digit, no digits
        send_number(MODE_BIN,  32'hAAAA_AAAA,  6'd32, 3'd1, 5'd1);
        send_number(MODE_BIN,  32'h5555_5555,  6'd63, 3'd7, 5'd31);
        send_number(MODE_BIN,  32'h0000_0001,  6'd1,  3'd2, 5'd16);
        send_number(MODE_BIN,  32'hFFFF_FFFF,  6'd0,  3'd3, 5'd2);
        send_number(MODE_BIN,  32'h0000_0000,  6'd33, 3'd0, 5'd0);

        // random numbers; long receiver hold-off at the start of this part
        hold_req <= 1'b1;
        for (int n = 0; n < RandItems; n++)
        begin
            calm <= (n >= 40 && n < 70);
            mode = mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       value = $urandom_range(0, 999);
                1:       value = 32'h8000_0000 + $urandom_range(0, 7) - 32'd4;
                2:       value = 32'd0 - $urandom_range(0, 100000);
                default: value = $urandom();
            endcase
            if ($urandom_range(0, 3) == 0)
                count = 6'($urandom_range(0, 63));
            else
                case (mode)
                    MODE_HEX: count = 6'($urandom_range(0, 8));
                    MODE_BIN: count = 6'($urandom_range(0, 32));
                    default:  count = 6'($urandom_range(0, 10));
                endcase
            send_number(mode, value, count, 3'($urandom_range(0, 7)),
                        5'($urandom_range(0, 31)));
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        // drain, then watch for stray output
        @(posedge clk);
        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("fixed_length_number_to_ascii_digits_top_tb passed");
        else
            $display("fixed_length_number_to_ascii_digits_top_tb failed");
        $finish;
    end

endmodule
